FILE: rtl/tec_pkg.sv
// Shared types and constants for the tank environment controller.
// No dependencies; used by every module under rtl/.
package tec_pkg;

  localparam int PADDR_W   = 5;
  localparam int TLEFT_W   = 6;
  localparam logic [11:0] PULSE_CLOSED = 12'd500;
  localparam logic [11:0] PULSE_OPEN   = 12'(500 + (90 * 2000) / 180);

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_SECOND  = 2'd1,
    MODE_RELAY   = 2'd2,
    MODE_IDLE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    BEEP_NONE    = 2'd0,
    BEEP_SILENT  = 2'd1,
    BEEP_ALARM   = 2'd2,
    BEEP_TIMEOUT = 2'd3
  } beep_t;

  typedef enum logic [2:0] {
    REG_FLAGS     = 3'd0,
    REG_TEMP_LO   = 3'd1,
    REG_TEMP_HI   = 3'd2,
    REG_LEVEL_WIN = 3'd3,
    REG_AIR_MIN   = 3'd4,
    REG_PH_LO     = 3'd5,
    REG_PH_HI     = 3'd6,
    REG_FEED_INT  = 3'd7
  } reg_addr_t;

  typedef struct packed {
    logic [1:0]         control_flags;
    logic signed [11:0] temp_lower;
    logic signed [11:0] temp_upper;
    logic [15:0]        level_window;
    logic [4:0]         air_min;
    logic [10:0]        ph_lower;
    logic [10:0]        ph_upper;
    logic [15:0]        feed_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [11:0] water_temp;
    logic [6:0]         water_level;
    logic [4:0]         air_quality;
    logic [10:0]        ph_value;
    logic [3:0]         relay_command;
  } item_t;

  typedef struct packed {
    logic               relay_heat;
    logic               relay_fill;
    logic               relay_drain;
    logic               relay_oxygen;
    logic               alarm_active;
    logic [1:0]         beep_command;
    logic [11:0]        servo_pulse;
    logic               feeding;
    logic [15:0]        feed_countdown;
    logic [TLEFT_W-1:0] timeout_left;
  } result_t;

endpackage

FILE: rtl/tec_cfg.sv
// APB-style configuration register file for the tank environment controller.
// Depends on tec_pkg.
module tec_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tec_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tec_pkg::cfg_t                cfg
);

  logic                wr_en;
  tec_pkg::reg_addr_t  addr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign addr   = tec_pkg::reg_addr_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_flags <= 2'd0;
      cfg.temp_lower    <= 12'sd384;
      cfg.temp_upper    <= 12'sd448;
      cfg.level_window  <= 16'd20510;
      cfg.air_min       <= 5'd10;
      cfg.ph_lower      <= 11'd650;
      cfg.ph_upper      <= 11'd850;
      cfg.feed_interval <= 16'd30;
    end else if (wr_en) begin
      case (addr)
        tec_pkg::REG_FLAGS:     cfg.control_flags <= pwdata[1:0];
        tec_pkg::REG_TEMP_LO:   cfg.temp_lower    <= pwdata[11:0];
        tec_pkg::REG_TEMP_HI:   cfg.temp_upper    <= pwdata[11:0];
        tec_pkg::REG_LEVEL_WIN: cfg.level_window  <= pwdata[15:0];
        tec_pkg::REG_AIR_MIN:   cfg.air_min       <= pwdata[4:0];
        tec_pkg::REG_PH_LO:     cfg.ph_lower      <= pwdata[10:0];
        tec_pkg::REG_PH_HI:     cfg.ph_upper      <= pwdata[10:0];
        tec_pkg::REG_FEED_INT:  cfg.feed_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (addr)
      tec_pkg::REG_FLAGS:     prdata = {30'd0, cfg.control_flags};
      tec_pkg::REG_TEMP_LO:   prdata = {20'd0, cfg.temp_lower};
      tec_pkg::REG_TEMP_HI:   prdata = {20'd0, cfg.temp_upper};
      tec_pkg::REG_LEVEL_WIN: prdata = {16'd0, cfg.level_window};
      tec_pkg::REG_AIR_MIN:   prdata = {27'd0, cfg.air_min};
      tec_pkg::REG_PH_LO:     prdata = {21'd0, cfg.ph_lower};
      tec_pkg::REG_PH_HI:     prdata = {21'd0, cfg.ph_upper};
      tec_pkg::REG_FEED_INT:  prdata = {16'd0, cfg.feed_interval};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/tec_core.sv
// Controller state and per-beat update logic: relays, alarm, safety timeout, feeder.
// Depends on tec_pkg.
module tec_core #(
  parameter int TIMEOUT_SECONDS = 60,
  parameter int OPEN_SECONDS    = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  tec_pkg::item_t   item,
  input  tec_pkg::cfg_t    cfg,
  output tec_pkg::result_t res
);

  localparam int SW = $clog2(TIMEOUT_SECONDS + 1);
  localparam int OW = $clog2(OPEN_SECONDS + 1);

  logic [3:0]    relay, relay_next;
  logic          alarm, alarm_next;
  logic [SW-1:0] safety, safety_next;
  logic [15:0]   feed_timer, feed_timer_next;
  logic [15:0]   feed_left, feed_left_next;
  logic          feed_active, feed_active_next;
  logic [OW-1:0] open_cnt, open_cnt_next;
  logic [11:0]   pulse, pulse_next;

  logic                   manual;
  logic [15:0]            timer_inc;
  logic [7:0]             level_min, level_max, level;
  tec_pkg::beep_t         beep;
  logic [SW+tec_pkg::TLEFT_W-1:0] safety_ext;

  assign manual    = cfg.control_flags[0];
  assign level_min = cfg.level_window[7:0];
  assign level_max = cfg.level_window[15:8];
  assign level     = {1'b0, item.water_level};

  always_comb begin
    relay_next       = relay;
    alarm_next       = alarm;
    safety_next      = safety;
    feed_timer_next  = feed_timer;
    feed_left_next   = feed_left;
    feed_active_next = feed_active;
    open_cnt_next    = open_cnt;
    pulse_next       = pulse;
    timer_inc        = feed_timer + 16'd1;
    beep             = tec_pkg::BEEP_NONE;
    case (item.mode)
      tec_pkg::MODE_CONTROL: begin
        if (!manual) begin
          if (item.water_temp < cfg.temp_lower) begin
            relay_next[0] = 1'b1;
          end else if (item.water_temp > cfg.temp_upper) begin
            relay_next[0] = 1'b0;
          end
          relay_next[2:1] = 2'b00;
          if (level > level_max) begin
            relay_next[2] = 1'b1;
          end else if (level < level_min) begin
            relay_next[1] = 1'b1;
          end
          relay_next[3] = item.air_quality < cfg.air_min;
        end
        alarm_next = (item.water_temp < cfg.temp_lower) ||
                     (item.water_temp > cfg.temp_upper) ||
                     (level < level_min) || (level > level_max) ||
                     (item.air_quality < cfg.air_min) ||
                     (item.ph_value < cfg.ph_lower) || (item.ph_value > cfg.ph_upper);
        beep = (alarm_next && cfg.control_flags[1]) ? tec_pkg::BEEP_ALARM
                                                    : tec_pkg::BEEP_SILENT;
      end
      tec_pkg::MODE_SECOND: begin
        if (manual && (relay != 4'd0)) begin
          if (safety != '0) begin
            safety_next = safety - 1'b1;
          end
          if (safety_next == '0) begin
            relay_next = 4'd0;
            beep       = tec_pkg::BEEP_TIMEOUT;
          end
        end else begin
          safety_next = SW'(TIMEOUT_SECONDS);
        end
        if (!manual) begin
          if (!feed_active) begin
            feed_timer_next = timer_inc;
            feed_left_next  = cfg.feed_interval - timer_inc;
            if (timer_inc >= cfg.feed_interval) begin
              feed_active_next = 1'b1;
              feed_timer_next  = 16'd0;
              open_cnt_next    = '0;
            end
          end
        end else begin
          feed_timer_next = 16'd0;
        end
        if (feed_active_next) begin
          if (feed_left_next != 16'd0) begin
            feed_left_next = feed_left_next - 16'd1;
          end
          if (open_cnt_next < OW'(OPEN_SECONDS)) begin
            pulse_next    = tec_pkg::PULSE_OPEN;
            open_cnt_next = open_cnt_next + 1'b1;
          end else begin
            pulse_next       = tec_pkg::PULSE_CLOSED;
            feed_active_next = 1'b0;
            open_cnt_next    = '0;
          end
        end else begin
          open_cnt_next = '0;
        end
      end
      tec_pkg::MODE_RELAY: begin
        relay_next = item.relay_command;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay       <= 4'd0;
      alarm       <= 1'b0;
      safety      <= SW'(TIMEOUT_SECONDS);
      feed_timer  <= 16'd0;
      feed_left   <= 16'd0;
      feed_active <= 1'b0;
      open_cnt    <= '0;
      pulse       <= tec_pkg::PULSE_CLOSED;
    end else if (en) begin
      relay       <= relay_next;
      alarm       <= alarm_next;
      safety      <= safety_next;
      feed_timer  <= feed_timer_next;
      feed_left   <= feed_left_next;
      feed_active <= feed_active_next;
      open_cnt    <= open_cnt_next;
      pulse       <= pulse_next;
    end
  end

  assign safety_ext = {{tec_pkg::TLEFT_W{1'b0}}, safety_next};

  always_comb begin
    res.relay_heat     = relay_next[0];
    res.relay_fill     = relay_next[1];
    res.relay_drain    = relay_next[2];
    res.relay_oxygen   = relay_next[3];
    res.alarm_active   = alarm_next;
    res.beep_command   = beep;
    res.servo_pulse    = pulse_next;
    res.feeding        = feed_active_next;
    res.feed_countdown = feed_left_next;
    res.timeout_left   = safety_ext[tec_pkg::TLEFT_W-1:0];
  end

endmodule

FILE: rtl/tank_environment_controller.sv
// Top level of the tank environment controller: stream ports, beat staging, APB port.
// Depends on tec_pkg, tec_cfg and tec_core.
//
// Usage:
//   Slave stream (s_*) takes one beat per item: s_tuser is the item kind
//   (0 control tick with sensor samples, 1 one-second tick, 2 manual relay
//   command, 3 ignored); s_tdata carries the samples and relay bits.
//   Master stream (m_*) returns exactly one status beat per input beat, in order.
//   Each beat passes through the input register, then the result register.
//   Throughput: one beat per cycle while m_tready stays high;
//   the update of the controller state is a single compare-and-count pass.
//   When m_tready is low the result register holds and one further beat is
//   kept in the input register; s_tready drops only when both are full.
//   Configuration goes through the APB port at byte address 4*index; the user
//   must write it only while the stream is idle (the block does not enforce this). pready is tied high.
//   Reset (rst, synchronous) clears both stages, sets registers to their
//   defaults, turns the relays off, closes the feeder and loads the safety
//   timeout with TIMEOUT_SECONDS.
module tank_environment_controller #(
  parameter int TIMEOUT_SECONDS = 60,
  parameter int OPEN_SECONDS    = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [11:0] water_temp, [18:12] water_level, [23:19] air_quality,
  // [34:24] ph_value, [38:35] relay_command, [39] zero
  input  logic [39:0]                  s_tdata,
  // [1:0] mode
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [0] relay_heat, [1] relay_fill, [2] relay_drain, [3] relay_oxygen,
  // [4] alarm_active, [6:5] beep_command, [18:7] servo_pulse, [19] feeding,
  // [35:20] feed_countdown, [41:36] timeout_left, [47:42] zero
  output logic [47:0]                  m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tec_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  tec_pkg::cfg_t    cfg;
  tec_pkg::item_t   in_item;
  logic             in_valid;
  tec_pkg::result_t res, out_res;
  logic             advance;
  logic             in_take;

  tec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tec_core #(
    .TIMEOUT_SECONDS (TIMEOUT_SECONDS),
    .OPEN_SECONDS    (OPEN_SECONDS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_take || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.mode          <= s_tuser;
      in_item.water_temp    <= s_tdata[11:0];
      in_item.water_level   <= s_tdata[18:12];
      in_item.air_quality   <= s_tdata[23:19];
      in_item.ph_value      <= s_tdata[34:24];
      in_item.relay_command <= s_tdata[38:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.timeout_left, out_res.feed_countdown, out_res.feeding,
                    out_res.servo_pulse, out_res.beep_command, out_res.alarm_active,
                    out_res.relay_oxygen, out_res.relay_drain, out_res.relay_fill,
                    out_res.relay_heat};

  // servo is open exactly while a feeding is in progress
  a_servo_feeding: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.feeding == (out_res.servo_pulse == tec_pkg::PULSE_OPEN)))
    else $error("servo pulse disagrees with feeding flag");

  a_closed_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.feeding |-> out_res.servo_pulse == tec_pkg::PULSE_CLOSED)
    else $error("servo not closed outside feeding");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without downstream stall");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("staged beat lost while stalled");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for tank_environment_controller: stream items in, status beats out.
// Predicts every status beat from its own copy of controller state; uses tec_pkg only.
// Configuration goes through the APB port between phases while the stream is idle.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_S = 60;
  localparam int OPEN_S    = 3;
  localparam int LIMIT     = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [11:0] water_temp, [18:12] water_level, [23:19] air_quality,
  // [34:24] ph_value, [38:35] relay_command, [39] zero
  logic [39:0] s_tdata = '0;
  // [1:0] mode
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] relay_heat, [1] relay_fill, [2] relay_drain, [3] relay_oxygen,
  // [4] alarm_active, [6:5] beep_command, [18:7] servo_pulse, [19] feeding,
  // [35:20] feed_countdown, [41:36] timeout_left, [47:42] zero
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tec_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tank_environment_controller #(
    .TIMEOUT_SECONDS(TIMEOUT_S),
    .OPEN_SECONDS(OPEN_S)
  ) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow configuration and controller state
  tec_pkg::cfg_t cfg;
  logic [3:0]  relays;
  logic        alarm_st;
  int          safety_cnt;
  logic [15:0] feed_tmr;
  logic [15:0] feed_rem;
  logic        feeding_st;
  int          open_cnt;
  logic [11:0] pulse;

  tec_pkg::result_t expected_status[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_pct = 0;
  int          hold_len = 0;
  int          hold_gen = 0;

  function automatic tec_pkg::cfg_t default_cfg();
    tec_pkg::cfg_t c;
    c.control_flags = 2'd0;
    c.temp_lower    = 12'sd384;
    c.temp_upper    = 12'sd448;
    c.level_window  = 16'd20510;
    c.air_min       = 5'd10;
    c.ph_lower      = 11'd650;
    c.ph_upper      = 11'd850;
    c.feed_interval = 16'd30;
    return c;
  endfunction

  function automatic tec_pkg::result_t predict_status(tec_pkg::item_t it);
    tec_pkg::result_t r;
    tec_pkg::beep_t   beep;
    int      t, tlo, thi;
    logic [7:0] lmin, lmax;
    logic    manual, alarm;
    beep = tec_pkg::BEEP_NONE;
    manual = cfg.control_flags[0];
    t = $signed(it.water_temp);
    tlo = $signed(cfg.temp_lower);
    thi = $signed(cfg.temp_upper);
    lmin = cfg.level_window[7:0];
    lmax = cfg.level_window[15:8];
    if (it.mode == tec_pkg::MODE_CONTROL) begin
      if (!manual) begin
        if (t < tlo) relays[0] = 1'b1;
        else if (t > thi) relays[0] = 1'b0;
        relays[2:1] = 2'b00;
        if (it.water_level > lmax) relays[2] = 1'b1;
        else if (it.water_level < lmin) relays[1] = 1'b1;
        relays[3] = (it.air_quality < cfg.air_min);
      end
      alarm = (t < tlo) || (t > thi) || (it.water_level < lmin) || (it.water_level > lmax) ||
              (it.air_quality < cfg.air_min) ||
              (it.ph_value < cfg.ph_lower) || (it.ph_value > cfg.ph_upper);
      alarm_st = alarm;
      beep = (alarm && cfg.control_flags[1]) ? tec_pkg::BEEP_ALARM : tec_pkg::BEEP_SILENT;
    end else if (it.mode == tec_pkg::MODE_SECOND) begin
      if (manual && relays != 4'd0) begin
        if (safety_cnt > 0) safety_cnt--;
        if (safety_cnt == 0) begin
          relays = 4'd0;
          beep = tec_pkg::BEEP_TIMEOUT;
        end
      end else begin
        safety_cnt = TIMEOUT_S;
      end
      if (!manual) begin
        if (!feeding_st) begin
          feed_tmr = feed_tmr + 16'd1;
          feed_rem = cfg.feed_interval - feed_tmr;
          if (feed_tmr >= cfg.feed_interval) begin
            feeding_st = 1'b1;
            feed_tmr = '0;
            open_cnt = 0;
          end
        end
      end else begin
        feed_tmr = '0;
      end
      if (feeding_st) begin
        if (feed_rem > 0) feed_rem--;
        if (open_cnt < OPEN_S) begin
          pulse = tec_pkg::PULSE_OPEN;
          open_cnt++;
        end else begin
          pulse = tec_pkg::PULSE_CLOSED;
          feeding_st = 1'b0;
          open_cnt = 0;
        end
      end else begin
        open_cnt = 0;
      end
    end else if (it.mode == tec_pkg::MODE_RELAY) begin
      relays = it.relay_command;
    end
    r.relay_heat     = relays[0];
    r.relay_fill     = relays[1];
    r.relay_drain    = relays[2];
    r.relay_oxygen   = relays[3];
    r.alarm_active   = alarm_st;
    r.beep_command   = beep;
    r.servo_pulse    = pulse;
    r.feeding        = feeding_st;
    r.feed_countdown = feed_rem;
    r.timeout_left   = safety_cnt[tec_pkg::TLEFT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : status_check
    tec_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        $error("status beat with no item outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = expected_status.pop_front();
        check_field("relay_heat", 16'(want.relay_heat), 16'(m_tdata[0]));
        check_field("relay_fill", 16'(want.relay_fill), 16'(m_tdata[1]));
        check_field("relay_drain", 16'(want.relay_drain), 16'(m_tdata[2]));
        check_field("relay_oxygen", 16'(want.relay_oxygen), 16'(m_tdata[3]));
        check_field("alarm_active", 16'(want.alarm_active), 16'(m_tdata[4]));
        check_field("beep_command", 16'(want.beep_command), 16'(m_tdata[6:5]));
        check_field("servo_pulse", 16'(want.servo_pulse), 16'(m_tdata[18:7]));
        check_field("feeding", 16'(want.feeding), 16'(m_tdata[19]));
        check_field("feed_countdown", want.feed_countdown, m_tdata[35:20]);
        check_field("timeout_left", 16'(want.timeout_left), 16'(m_tdata[41:36]));
      end
    end
  end

  // sink side: random gaps, plus a long hold-off on request
  always @(posedge clk) begin : sink
    int r;
    int rx_gap;
    int hold_left;
    int hold_seen;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
      hold_seen = hold_gen;
    end else if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = hold_len - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < gap_pct) rx_gap = $urandom_range(1, 3);
      else if (gap_pct > 0 && r < gap_pct + 2) rx_gap = $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tank_environment_controller verification failed");
      $finish;
    end
  end

  task automatic cfg_write(tec_pkg::reg_addr_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      tec_pkg::REG_FLAGS:     cfg.control_flags = v[1:0];
      tec_pkg::REG_TEMP_LO:   cfg.temp_lower    = v[11:0];
      tec_pkg::REG_TEMP_HI:   cfg.temp_upper    = v[11:0];
      tec_pkg::REG_LEVEL_WIN: cfg.level_window  = v[15:0];
      tec_pkg::REG_AIR_MIN:   cfg.air_min       = v[4:0];
      tec_pkg::REG_PH_LO:     cfg.ph_lower      = v[10:0];
      tec_pkg::REG_PH_HI:     cfg.ph_upper      = v[10:0];
      tec_pkg::REG_FEED_INT:  cfg.feed_interval = v[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_write_all(tec_pkg::cfg_t c);
    cfg_write(tec_pkg::REG_FLAGS, {30'h0, c.control_flags});
    cfg_write(tec_pkg::REG_TEMP_LO, {20'h0, c.temp_lower});
    cfg_write(tec_pkg::REG_TEMP_HI, {20'h0, c.temp_upper});
    cfg_write(tec_pkg::REG_LEVEL_WIN, {16'h0, c.level_window});
    cfg_write(tec_pkg::REG_AIR_MIN, {27'h0, c.air_min});
    cfg_write(tec_pkg::REG_PH_LO, {21'h0, c.ph_lower});
    cfg_write(tec_pkg::REG_PH_HI, {21'h0, c.ph_upper});
    cfg_write(tec_pkg::REG_FEED_INT, {16'h0, c.feed_interval});
  endtask

  task automatic send_item(tec_pkg::item_t it);
    int r;
    int k;
    k = 0;
    r = $urandom_range(0, 99);
    if (r < gap_pct) k = $urandom_range(1, 3);
    else if (gap_pct > 0 && r < gap_pct + 2) k = $urandom_range(10, 40);
    if (k > 0) begin
      s_tvalid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, it.relay_command, it.ph_value, it.air_quality,
                 it.water_level, it.water_temp};
    s_tuser  <= it.mode;
    do @(posedge clk); while (!s_tready);
    expected_status.push_back(predict_status(it));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic tec_pkg::item_t sample(logic [1:0] mode, int temp, int level, int air,
                                            int ph, int relay);
    tec_pkg::item_t it;
    it.mode          = mode;
    it.water_temp    = 12'(temp);
    it.water_level   = 7'(level);
    it.air_quality   = 5'(air);
    it.ph_value      = 11'(ph);
    it.relay_command = 4'(relay);
    return it;
  endfunction

  function automatic int near(int center, int lo, int hi);
    int v;
    v = center + int'($urandom_range(0, 4)) - 2;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic tec_pkg::item_t rand_item();
    int r, temp, level, air, ph, relay;
    logic [1:0] mode;
    r = $urandom_range(0, 99);
    if (cfg.control_flags[0]) begin
      if (r < 60) mode = tec_pkg::MODE_SECOND;
      else if (r < 85) mode = tec_pkg::MODE_RELAY;
      else if (r < 96) mode = tec_pkg::MODE_CONTROL;
      else mode = tec_pkg::MODE_IDLE;
    end else begin
      if (r < 40) mode = tec_pkg::MODE_CONTROL;
      else if (r < 80) mode = tec_pkg::MODE_SECOND;
      else if (r < 96) mode = tec_pkg::MODE_RELAY;
      else mode = tec_pkg::MODE_IDLE;
    end
    case ($urandom_range(0, 3))
      0: temp = int'($urandom_range(0, 2880)) - 880;
      1: temp = near($signed(cfg.temp_lower), -880, 2000);
      2: temp = near($signed(cfg.temp_upper), -880, 2000);
      default: temp = $urandom_range(0, 1) ? 2000 : -880;
    endcase
    case ($urandom_range(0, 2))
      0: level = $urandom_range(0, 100);
      1: level = near(cfg.level_window[7:0], 0, 100);
      default: level = near(cfg.level_window[15:8], 0, 100);
    endcase
    air = $urandom_range(0, 1) ? int'($urandom_range(0, 20)) : near(cfg.air_min, 0, 20);
    case ($urandom_range(0, 2))
      0: ph = $urandom_range(0, 1400);
      1: ph = near(cfg.ph_lower, 0, 1400);
      default: ph = near(cfg.ph_upper, 0, 1400);
    endcase
    if (cfg.control_flags[0] && $urandom_range(0, 9) != 0) relay = $urandom_range(1, 15);
    else relay = $urandom_range(0, 15);
    return sample(mode, temp, level, air, ph, relay);
  endfunction

  function automatic tec_pkg::cfg_t rand_cfg();
    tec_pkg::cfg_t c;
    int r;
    c.control_flags = 2'($urandom_range(0, 3));
    c.temp_lower    = 12'(int'($urandom_range(0, 2880)) - 880);
    c.temp_upper    = $urandom_range(0, 3) == 0 ? 12'(int'($urandom_range(0, 2880)) - 880)
                                               : 12'($signed(c.temp_lower) +
                                                     int'($urandom_range(0, 100)));
    if ($urandom_range(0, 4) == 0) c.level_window = 16'($urandom);
    else c.level_window = {8'($urandom_range(0, 100)), 8'($urandom_range(0, 100))};
    c.air_min  = 5'($urandom_range(0, 20));
    c.ph_lower = 11'($urandom_range(0, 1400));
    c.ph_upper = 11'($urandom_range(0, 1400));
    r = $urandom_range(0, 9);
    if (r == 0) c.feed_interval = 16'd0;
    else if (r == 1) c.feed_interval = 16'($urandom_range(20, 65535));
    else c.feed_interval = 16'($urandom_range(1, 6));
    return c;
  endfunction

  task automatic test_directed();
    tec_pkg::cfg_t c;
    c = default_cfg();
    c.control_flags = 2'b10;
    c.feed_interval = 16'd2;
    cfg_write_all(c);
    gap_pct = 10;
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, -880, 50, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 2000, 50, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 0, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 100, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 0, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 20, 750, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 15, 0, 0));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 15, 1400, 0));
    // relay command in auto mode, then overridden by the next control tick
    send_item(sample(tec_pkg::MODE_RELAY, 0, 0, 0, 0, 15));
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 15, 750, 0));
    send_item(sample(tec_pkg::MODE_IDLE, -1, 127, 31, 2047, 15));
    repeat (5) send_item(sample(tec_pkg::MODE_SECOND, 0, 0, 0, 0, 0));
    wait_idle();
    // inverted level window and zero feed interval
    cfg_write(tec_pkg::REG_LEVEL_WIN, 32'h0000_1450);
    cfg_write(tec_pkg::REG_FEED_INT, 32'h0);
    send_item(sample(tec_pkg::MODE_CONTROL, 416, 50, 15, 750, 0));
    repeat (4) send_item(sample(tec_pkg::MODE_SECOND, 0, 0, 0, 0, 0));
    wait_idle();
    cfg_write(tec_pkg::REG_FLAGS, 32'h3);
    send_item(sample(tec_pkg::MODE_RELAY, 0, 0, 0, 0, 5));
    send_item(sample(tec_pkg::MODE_CONTROL, -880, 0, 0, 0, 0));
    send_item(sample(tec_pkg::MODE_SECOND, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_backpressure();
    tec_pkg::cfg_t c;
    c = rand_cfg();
    c.control_flags[0] = 1'b0;
    cfg_write_all(c);
    gap_pct = 0;
    hold_len = 80;
    hold_gen++;
    repeat (30) send_item(rand_item());
    wait_idle();
  endtask

  task automatic test_random_phases();
    tec_pkg::cfg_t c;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          c = default_cfg();
          c.feed_interval = 16'd3;
        end
        1: begin
          c.control_flags = 2'b00;
          c.temp_lower = -12'sd880;
          c.temp_upper = -12'sd880;
          c.level_window = 16'd0;
          c.air_min = 5'd0;
          c.ph_lower = 11'd0;
          c.ph_upper = 11'd0;
          c.feed_interval = 16'd1;
        end
        2: begin
          c.control_flags = 2'b11;
          c.temp_lower = 12'sd2000;
          c.temp_upper = 12'sd2000;
          c.level_window = 16'hFFFF;
          c.air_min = 5'd20;
          c.ph_lower = 11'd1400;
          c.ph_upper = 11'd1400;
          c.feed_interval = 16'hFFFF;
        end
        default: begin
          c = rand_cfg();
          c.control_flags[0] = p[0];
        end
      endcase
      cfg_write_all(c);
      gap_pct = (p == 0) ? 0 : int'($urandom_range(5, 30));
      repeat (c.control_flags[0] ? 130 : 100) send_item(rand_item());
      wait_idle();
    end
  endtask

  initial begin
    cfg = default_cfg();
    relays = '0;
    alarm_st = 1'b0;
    safety_cnt = TIMEOUT_S;
    feed_tmr = '0;
    feed_rem = '0;
    feeding_st = 1'b0;
    open_cnt = 0;
    pulse = tec_pkg::PULSE_CLOSED;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tank_environment_controller verification clean");
    end else begin
      $display("tank_environment_controller verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tec_pkg.sv
rtl/tec_cfg.sv
rtl/tec_core.sv
rtl/tank_environment_controller.sv
tb/tb.sv
